[rtl/scene_text_lexer_defines.svh]
// Assertion macros shared by the scene text lexer modules.
`ifndef SCENE_TEXT_LEXER_DEFINES_SVH
`define SCENE_TEXT_LEXER_DEFINES_SVH
`ifndef SYNTH
// Checks that an expression holds at every clock edge out of reset.
`define SCL_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);
// Checks that a condition implies a consequence in the same cycle.
`define SCL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Checks that a condition implies a consequence in the next cycle.
`define SCL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SCL_ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define SCL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define SCL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/scl_pkg.sv]
// Types, codes and character constants shared by the scene text lexer.
package scl_pkg;

    // Token kinds on the result channel.
    localparam logic [3:0] KIND_STRING    = 4'd0;
    localparam logic [3:0] KIND_COMPONENT = 4'd1;
    localparam logic [3:0] KIND_IDENT     = 4'd2;
    localparam logic [3:0] KIND_PARAM     = 4'd3;
    localparam logic [3:0] KIND_COLON     = 4'd4;
    localparam logic [3:0] KIND_NUMBER    = 4'd5;
    localparam logic [3:0] KIND_LBRACE    = 4'd6;
    localparam logic [3:0] KIND_RBRACE    = 4'd7;
    localparam logic [3:0] KIND_LSQUARE   = 4'd8;
    localparam logic [3:0] KIND_RSQUARE   = 4'd9;
    localparam logic [3:0] KIND_ERROR     = 4'd10;
    localparam logic [3:0] KIND_DONE      = 4'd11;

    // Error codes.
    localparam logic [2:0] ERR_NONE          = 3'd0;
    localparam logic [2:0] ERR_UNTERMINATED  = 3'd1;
    localparam logic [2:0] ERR_NO_COMP_NAME  = 3'd2;
    localparam logic [2:0] ERR_NO_DIGITS     = 3'd3;
    localparam logic [2:0] ERR_BAD_NUM_END   = 3'd4;
    localparam logic [2:0] ERR_UNKNOWN_CHAR  = 3'd5;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_POINT   = 8'h2E;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_LSQUARE = 8'h5B;
    localparam logic [7:0] CH_RSQUARE = 8'h5D;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_UNDER   = 8'h5F;

    // Bundles held between front and back.
    localparam int QDEPTH = 4;
    localparam int MAX_RESULTS = 3;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_SLASH,
        MODE_COMMENT,
        MODE_STRING,
        MODE_COMPONENT,
        MODE_IDENT,
        MODE_NUMBER
    } mode_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [2:0]  code;
        logic [31:0] line;
        logic [31:0] offset;
        logic [15:0] length;
    } result_t;

    // All results caused by one input byte, in order; count is at least 1 when queued.
    typedef struct packed {
        logic [1:0]                  count;
        result_t [MAX_RESULTS-1:0]   res;
    } bundle_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Appends one result to a bundle.
    function automatic bundle_t bundle_append(bundle_t b, result_t r);
        bundle_t o;
        o = b;
        if (b.count != 2'(MAX_RESULTS))
        begin
            o.res[b.count] = r;
            o.count = b.count + 2'd1;
        end
        return o;
    endfunction

endpackage

[rtl/scl_front.sv]
// Front part of the lexer: takes one byte a beat, tracks state and builds the result bundle.
module scl_front #(
    parameter int OFFSET_BITS = 32,
    parameter int LENGTH_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       text_byte,
    input  logic             end_of_document,
    input  logic             text_valid,
    output logic             text_ready,
    output logic             push_valid,
    output scl_pkg::bundle_t push_bundle,
    input  scl_pkg::queue_status_t q_status
);
    import scl_pkg::*;

    localparam int OXW = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;
    localparam int LXW = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

    mode_t                  mode_reg, mode_next;
    logic [31:0]            line_reg, line_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic                   digit_reg, digit_next;
    logic                   point_reg, point_next;
    logic                   halted_reg, halted_next;
    bundle_t                bundle_next;

    logic                   accept;
    logic [OFFSET_BITS-1:0] pos_after;
    logic [LENGTH_BITS-1:0] len_grown;
    logic                   do_idle;
    logic                   fail_hit;
    logic [2:0]             fail_code;
    logic                   is_alpha, is_digit, is_space, is_name;

    // Builds one result, saturating offset and length to the port widths.
    function automatic result_t make_result(logic [3:0] kind, logic [2:0] code,
                                            logic [31:0] line,
                                            logic [OFFSET_BITS-1:0] offs,
                                            logic [LENGTH_BITS-1:0] len);
        result_t          r;
        logic [OXW-1:0]   oext;
        logic [LXW-1:0]   lext;
        oext = OXW'(offs);
        lext = LXW'(len);
        r.kind = kind;
        r.code = code;
        r.line = line;
        r.offset = (oext > OXW'(64'hFFFF_FFFF)) ? 32'hFFFF_FFFF : oext[31:0];
        r.length = (lext > LXW'(32'hFFFF)) ? 16'hFFFF : lext[15:0];
        return r;
    endfunction

    // Character classes of the incoming byte.
    assign is_alpha = ((text_byte >= 8'h41) && (text_byte <= 8'h5A)) ||
                      ((text_byte >= 8'h61) && (text_byte <= 8'h7A));
    assign is_digit = (text_byte >= 8'h30) && (text_byte <= 8'h39);
    assign is_space = (text_byte == 8'h20) || (text_byte == 8'h09) || (text_byte == 8'h0B) ||
                      (text_byte == 8'h0C) || (text_byte == 8'h0D);
    assign is_name  = is_alpha || (text_byte == CH_UNDER);

    assign pos_after = (offset_reg != '1) ? offset_reg + 1'b1 : offset_reg;
    assign len_grown = (len_reg != '1) ? len_reg + 1'b1 : len_reg;

    // Handshake and queue push.
    always_comb
    begin
        text_ready  = !q_status.full;
        accept      = text_valid && text_ready;
        push_valid  = accept && (bundle_next.count != 2'd0);
        push_bundle = bundle_next;
    end

    // Lexer step for the byte on the input.
    always_comb
    begin
        mode_next   = mode_reg;
        line_next   = line_reg;
        offset_next = offset_reg;
        start_next  = start_reg;
        len_next    = len_reg;
        digit_next  = digit_reg;
        point_next  = point_reg;
        halted_next = halted_reg;
        bundle_next = '0;
        do_idle     = 1'b0;
        fail_hit    = 1'b0;
        fail_code   = ERR_NONE;

        if (!halted_reg)
        begin
            offset_next = pos_after;

            // Continue the token in progress.
            case (mode_reg)
                MODE_SLASH:
                begin
                    if (text_byte == CH_SLASH)
                    begin
                        mode_next = MODE_COMMENT;
                    end
                    else
                    begin
                        fail_hit  = 1'b1;
                        fail_code = ERR_UNKNOWN_CHAR;
                    end
                end
                MODE_COMMENT:
                begin
                    if (text_byte == CH_NEWLINE)
                    begin
                        mode_next = MODE_IDLE;
                        do_idle   = 1'b1;
                    end
                end
                MODE_STRING:
                begin
                    if (text_byte == CH_QUOTE)
                    begin
                        bundle_next = bundle_append(bundle_next,
                            make_result(KIND_STRING, ERR_NONE, line_next, start_reg, len_reg));
                        mode_next = MODE_IDLE;
                    end
                    else if (text_byte == CH_NEWLINE)
                    begin
                        fail_hit  = 1'b1;
                        fail_code = ERR_UNTERMINATED;
                    end
                    else
                    begin
                        len_next = len_grown;
                    end
                end
                MODE_COMPONENT:
                begin
                    if (is_name)
                    begin
                        len_next = len_grown;
                    end
                    else if (len_reg == '0)
                    begin
                        fail_hit  = 1'b1;
                        fail_code = ERR_NO_COMP_NAME;
                    end
                    else
                    begin
                        bundle_next = bundle_append(bundle_next,
                            make_result(KIND_COMPONENT, ERR_NONE, line_next, start_reg, len_reg));
                        mode_next = MODE_IDLE;
                        do_idle   = 1'b1;
                    end
                end
                MODE_IDENT:
                begin
                    if (is_name)
                    begin
                        len_next = len_grown;
                    end
                    else if (text_byte == CH_COLON)
                    begin
                        bundle_next = bundle_append(bundle_next,
                            make_result(KIND_PARAM, ERR_NONE, line_next, start_reg, len_reg));
                        bundle_next = bundle_append(bundle_next,
                            make_result(KIND_COLON, ERR_NONE, line_next, offset_reg,
                                        LENGTH_BITS'(1)));
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        bundle_next = bundle_append(bundle_next,
                            make_result(KIND_IDENT, ERR_NONE, line_next, start_reg, len_reg));
                        mode_next = MODE_IDLE;
                        do_idle   = 1'b1;
                    end
                end
                MODE_NUMBER:
                begin
                    if (is_digit)
                    begin
                        digit_next = 1'b1;
                        len_next   = len_grown;
                    end
                    else if ((text_byte == CH_POINT) && !point_reg)
                    begin
                        point_next = 1'b1;
                        len_next   = len_grown;
                    end
                    else if (!digit_reg)
                    begin
                        fail_hit  = 1'b1;
                        fail_code = ERR_NO_DIGITS;
                    end
                    else if (is_alpha || (text_byte == CH_POINT))
                    begin
                        fail_hit  = 1'b1;
                        fail_code = ERR_BAD_NUM_END;
                    end
                    else
                    begin
                        bundle_next = bundle_append(bundle_next,
                            make_result(KIND_NUMBER, ERR_NONE, line_next, start_reg, len_reg));
                        mode_next = MODE_IDLE;
                        do_idle   = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                    do_idle   = 1'b1;
                end
            endcase

            // Lex the byte from the idle mode.
            if (do_idle)
            begin
                if (text_byte == CH_NEWLINE)
                begin
                    if (line_reg != '1)
                    begin
                        line_next = line_reg + 32'd1;
                    end
                end
                else if (is_space || (text_byte == CH_COMMA))
                begin
                    mode_next = MODE_IDLE;
                end
                else if (text_byte == CH_SLASH)
                begin
                    mode_next = MODE_SLASH;
                end
                else if ((text_byte == CH_QUOTE) || (text_byte == CH_AT))
                begin
                    mode_next  = (text_byte == CH_QUOTE) ? MODE_STRING : MODE_COMPONENT;
                    start_next = pos_after;
                    len_next   = '0;
                end
                else if (is_alpha)
                begin
                    mode_next  = MODE_IDENT;
                    start_next = offset_reg;
                    len_next   = LENGTH_BITS'(1);
                end
                else if (is_digit || (text_byte == CH_MINUS))
                begin
                    mode_next  = MODE_NUMBER;
                    start_next = offset_reg;
                    len_next   = LENGTH_BITS'(1);
                    digit_next = is_digit;
                    point_next = 1'b0;
                end
                else if (text_byte == CH_LBRACE)
                begin
                    bundle_next = bundle_append(bundle_next,
                        make_result(KIND_LBRACE, ERR_NONE, line_next, offset_reg,
                                    LENGTH_BITS'(1)));
                end
                else if (text_byte == CH_RBRACE)
                begin
                    bundle_next = bundle_append(bundle_next,
                        make_result(KIND_RBRACE, ERR_NONE, line_next, offset_reg,
                                    LENGTH_BITS'(1)));
                end
                else if (text_byte == CH_LSQUARE)
                begin
                    bundle_next = bundle_append(bundle_next,
                        make_result(KIND_LSQUARE, ERR_NONE, line_next, offset_reg,
                                    LENGTH_BITS'(1)));
                end
                else if (text_byte == CH_RSQUARE)
                begin
                    bundle_next = bundle_append(bundle_next,
                        make_result(KIND_RSQUARE, ERR_NONE, line_next, offset_reg,
                                    LENGTH_BITS'(1)));
                end
                else if (text_byte == CH_COLON)
                begin
                    bundle_next = bundle_append(bundle_next,
                        make_result(KIND_COLON, ERR_NONE, line_next, offset_reg,
                                    LENGTH_BITS'(1)));
                end
                else
                begin
                    fail_hit  = 1'b1;
                    fail_code = ERR_UNKNOWN_CHAR;
                end
            end

            // Close whatever is pending at the end of the document.
            if (end_of_document && !fail_hit)
            begin
                case (mode_next)
                    MODE_SLASH:
                    begin
                        fail_hit  = 1'b1;
                        fail_code = ERR_UNKNOWN_CHAR;
                    end
                    MODE_STRING:
                    begin
                        fail_hit  = 1'b1;
                        fail_code = ERR_UNTERMINATED;
                    end
                    MODE_COMPONENT:
                    begin
                        if (len_next == '0)
                        begin
                            fail_hit  = 1'b1;
                            fail_code = ERR_NO_COMP_NAME;
                        end
                        else
                        begin
                            bundle_next = bundle_append(bundle_next,
                                make_result(KIND_COMPONENT, ERR_NONE, line_next, start_next,
                                            len_next));
                        end
                    end
                    MODE_IDENT:
                    begin
                        bundle_next = bundle_append(bundle_next,
                            make_result(KIND_IDENT, ERR_NONE, line_next, start_next, len_next));
                    end
                    MODE_NUMBER:
                    begin
                        if (!digit_next)
                        begin
                            fail_hit  = 1'b1;
                            fail_code = ERR_NO_DIGITS;
                        end
                        else
                        begin
                            bundle_next = bundle_append(bundle_next,
                                make_result(KIND_NUMBER, ERR_NONE, line_next, start_next,
                                            len_next));
                        end
                    end
                    default:
                    begin
                        mode_next = mode_next;
                    end
                endcase
            end

            // An error is always the last result of its byte.
            if (fail_hit)
            begin
                bundle_next = bundle_append(bundle_next,
                    make_result(KIND_ERROR, fail_code, line_next, '0, '0));
                halted_next = 1'b1;
                mode_next   = MODE_IDLE;
            end
            else if (end_of_document)
            begin
                bundle_next = bundle_append(bundle_next,
                    make_result(KIND_DONE, ERR_NONE, line_next, '0, '0));
            end
        end

        // The final byte returns every document state to its reset value.
        if (end_of_document)
        begin
            mode_next   = MODE_IDLE;
            line_next   = 32'd1;
            offset_next = '0;
            start_next  = '0;
            len_next    = '0;
            digit_next  = 1'b0;
            point_next  = 1'b0;
            halted_next = 1'b0;
        end
    end

    // Document state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            line_reg   <= 32'd1;
            offset_reg <= '0;
            start_reg  <= '0;
            len_reg    <= '0;
            digit_reg  <= 1'b0;
            point_reg  <= 1'b0;
            halted_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            line_reg   <= line_next;
            offset_reg <= offset_next;
            start_reg  <= start_next;
            len_reg    <= len_next;
            digit_reg  <= digit_next;
            point_reg  <= point_next;
            halted_reg <= halted_next;
        end
    end

endmodule

[rtl/scl_queue.sv]
// Short queue of result bundles between the lexer front and the output back.
`include "scene_text_lexer_defines.svh"
module scl_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push_valid,
    input  scl_pkg::bundle_t       push_bundle,
    input  logic                   pop,
    output scl_pkg::bundle_t       head_bundle,
    output scl_pkg::queue_status_t q_status
);
    import scl_pkg::*;

    localparam int QAW = $clog2(QDEPTH);

    bundle_t          mem_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]     count_reg, count_next;

    // Status and head entry.
    always_comb
    begin
        q_status.full  = (count_reg == (QAW+1)'(QDEPTH));
        q_status.empty = (count_reg == '0);
        head_bundle    = mem_reg[rd_ptr_reg];
        count_next     = count_reg + (QAW+1)'(push_valid) - (QAW+1)'(pop);
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            mem_reg[wr_ptr_reg] <= push_bundle;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    `SCL_ASSERT_ALWAYS(a_no_overflow, clk, rst_n, !(push_valid && q_status.full), "push into full queue")
    `SCL_ASSERT_ALWAYS(a_no_underflow, clk, rst_n, !(pop && q_status.empty), "pop from empty queue")
    `SCL_ASSERT_IMPL(a_push_nonempty, clk, rst_n, push_valid, push_bundle.count != 2'd0, "empty bundle pushed")
    `SCL_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= (QAW+1)'(QDEPTH), "fill count beyond depth")

endmodule

[rtl/scl_back.sv]
// Back part of the lexer: unpacks bundles and drives the result channel one beat at a time.
`include "scene_text_lexer_defines.svh"
module scl_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  scl_pkg::bundle_t       head_bundle,
    input  scl_pkg::queue_status_t q_status,
    output logic                   pop,
    output logic                   result_valid,
    input  logic                   result_ready,
    output logic [3:0]             result_kind,
    output logic [2:0]             error_code,
    output logic [31:0]            line_number,
    output logic [31:0]            start_offset,
    output logic [15:0]            text_length,
    output logic                   last_of_run
);
    import scl_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    result_t    res_reg;
    logic       last_reg;
    logic       load;
    logic       idx_last;
    result_t    pick;

    // Select the next result of the head bundle.
    always_comb
    begin
        load       = !q_status.empty && (!valid_reg || result_ready);
        idx_last   = (idx_reg == (head_bundle.count - 2'd1));
        pop        = load && idx_last;
        pick       = head_bundle.res[idx_reg];
        idx_next   = load ? (idx_last ? 2'd0 : idx_reg + 2'd1) : idx_reg;
        valid_next = load || (valid_reg && !result_ready);
    end

    // Output register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg  <= pick;
            last_reg <= idx_last;
        end
    end

    assign result_valid = valid_reg;
    assign result_kind  = res_reg.kind;
    assign error_code   = res_reg.code;
    assign line_number  = res_reg.line;
    assign start_offset = res_reg.offset;
    assign text_length  = res_reg.length;
    assign last_of_run  = last_reg;

    `SCL_ASSERT_IMPL(a_idx_in_bundle, clk, rst_n, !q_status.empty, idx_reg < head_bundle.count, "index past bundle")
    `SCL_ASSERT_IMPL(a_kind_range, clk, rst_n, valid_reg, res_reg.kind <= KIND_DONE, "result kind out of range")
    `SCL_ASSERT_IMPL(a_code_on_error, clk, rst_n, valid_reg, (res_reg.kind == KIND_ERROR) == (res_reg.code != ERR_NONE), "error code mismatch")
    `SCL_ASSERT_NEXT(a_pop_marks_last, clk, rst_n, pop, last_reg && valid_reg, "bundle popped before its last beat")

endmodule

[rtl/scene_text_lexer.sv]
// Top level of the scene text lexer: front, bundle queue and output back.
//
//  Channel  | Handshake                    | Payload
//  ---------+------------------------------+---------------------------------------------
//  text     | text_valid / text_ready      | text_byte, end_of_document
//  result   | result_valid / result_ready  | result_kind, error_code, line_number,
//           |                              | start_offset, text_length, last_of_run
//
// One byte is taken every cycle while the four-entry bundle queue has room; the front lexes it
// in that same cycle. A byte's results pass through a queue entry and then the output register.
// The result channel gives one result a cycle while result_ready is high, so a byte with three
// results holds the output for all of its result beats; the queue absorbs such bursts before text_ready falls.
// Reset (rst_n, asynchronous) returns the lexer to the start of a document and empties the queue.
module scene_text_lexer #(
    parameter int OFFSET_BITS = 32,
    parameter int LENGTH_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        text_valid,
    output logic        text_ready,
    input  logic [7:0]  text_byte,
    input  logic        end_of_document,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [3:0]  result_kind,
    output logic [2:0]  error_code,
    output logic [31:0] line_number,
    output logic [31:0] start_offset,
    output logic [15:0] text_length,
    output logic        last_of_run
);
    import scl_pkg::*;

    logic          push_valid;
    bundle_t       push_bundle;
    bundle_t       head_bundle;
    queue_status_t q_status;
    logic          pop;

    // Lexer front.
    scl_front #(
        .OFFSET_BITS (OFFSET_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .text_byte       (text_byte),
        .end_of_document (end_of_document),
        .text_valid      (text_valid),
        .text_ready      (text_ready),
        .push_valid      (push_valid),
        .push_bundle     (push_bundle),
        .q_status        (q_status)
    );

    // Bundle queue.
    scl_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_valid  (push_valid),
        .push_bundle (push_bundle),
        .pop         (pop),
        .head_bundle (head_bundle),
        .q_status    (q_status)
    );

    // Result output.
    scl_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_bundle  (head_bundle),
        .q_status     (q_status),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_kind  (result_kind),
        .error_code   (error_code),
        .line_number  (line_number),
        .start_offset (start_offset),
        .text_length  (text_length),
        .last_of_run  (last_of_run)
    );

endmodule

[sim/testbench.sv]
// Self-checking testbench for the scene text lexer: byte stream in, predicted tokens compared out.
module testbench;
    import scl_pkg::*;

    // Whitespace bytes that the lexer skips, beside newline and comma.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VTAB  = 8'h0B;
    localparam logic [7:0] CH_FEED  = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int STALL_CYCLES = 300;
    localparam int DRAIN_CYCLES = 10;

    typedef struct {
        logic [3:0]  kind;
        logic [2:0]  code;
        logic [31:0] line;
        logic [31:0] offset;
        logic [15:0] text_len;
        logic        last;
    } lexed_token_t;

    function automatic bit is_letter(logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic bit is_name_char(logic [7:0] c);
        return is_letter(c) || c == CH_UNDER;
    endfunction

    // Tracks the lexer state per beat and holds the tokens still owed by the block.
    class token_scoreboard;
        mode_t        mode;
        bit [31:0]    line_cnt;
        bit [31:0]    pos;
        bit [31:0]    tok_start;
        bit [15:0]    tok_len;
        bit           seen_digit;
        bit           seen_point;
        bit           halted;
        lexed_token_t burst[$];
        lexed_token_t pending_tokens[$];
        int           errors;

        function new();
            errors = 0;
            clear_doc();
        endfunction

        function void clear_doc();
            mode       = MODE_IDLE;
            line_cnt   = 1;
            pos        = 0;
            tok_start  = 0;
            tok_len    = 0;
            seen_digit = 0;
            seen_point = 0;
            halted     = 0;
        endfunction

        function void push_token(logic [3:0] kind, logic [2:0] code, bit [31:0] offset,
                                 bit [15:0] text_len);
            lexed_token_t t;
            if (burst.size() < MAX_RESULTS)
            begin
                t.kind     = kind;
                t.code     = code;
                t.line     = line_cnt;
                t.offset   = offset;
                t.text_len = text_len;
                t.last     = 1'b0;
                burst.insert(burst.size(), t);
            end
        endfunction

        function void raise_error(logic [2:0] code);
            push_token(KIND_ERROR, code, 0, 0);
            halted = 1;
            mode   = MODE_IDLE;
        endfunction

        function void start_token(mode_t m, bit [31:0] s, bit [15:0] len);
            mode      = m;
            tok_start = s;
            tok_len   = len;
        endfunction

        function void grow();
            if (tok_len != '1)
                tok_len++;
        endfunction

        // Lexes a byte that arrives with no token open.
        function void lex_idle(logic [7:0] c, bit [31:0] p);
            bit [31:0] next;
            next = (p != '1) ? p + 1 : p;
            if (c == CH_NEWLINE)
            begin
                if (line_cnt != '1)
                    line_cnt++;
            end
            else if (c == CH_SPACE || c == CH_TAB || c == CH_VTAB || c == CH_FEED ||
                     c == CH_CR || c == CH_COMMA)
            begin
            end
            else if (c == CH_SLASH)
                mode = MODE_SLASH;
            else if (c == CH_QUOTE)
                start_token(MODE_STRING, next, 0);
            else if (c == CH_AT)
                start_token(MODE_COMPONENT, next, 0);
            else if (is_letter(c))
                start_token(MODE_IDENT, p, 1);
            else if (is_digit(c) || c == CH_MINUS)
            begin
                start_token(MODE_NUMBER, p, 1);
                seen_digit = is_digit(c);
                seen_point = 0;
            end
            else if (c == CH_LBRACE)
                push_token(KIND_LBRACE, ERR_NONE, p, 1);
            else if (c == CH_RBRACE)
                push_token(KIND_RBRACE, ERR_NONE, p, 1);
            else if (c == CH_LSQUARE)
                push_token(KIND_LSQUARE, ERR_NONE, p, 1);
            else if (c == CH_RSQUARE)
                push_token(KIND_RSQUARE, ERR_NONE, p, 1);
            else if (c == CH_COLON)
                push_token(KIND_COLON, ERR_NONE, p, 1);
            else
                raise_error(ERR_UNKNOWN_CHAR);
        endfunction

        // Predicts the tokens of one accepted beat; returns whether the byte was lexed.
        function bit note_text_beat(logic [7:0] c, logic eod);
            bit live;
            live = !halted;
            burst.delete();
            if (!halted)
            begin
                case (mode)
                    MODE_SLASH:
                    begin
                        if (c == CH_SLASH)
                            mode = MODE_COMMENT;
                        else
                            raise_error(ERR_UNKNOWN_CHAR);
                    end
                    MODE_COMMENT:
                    begin
                        if (c == CH_NEWLINE)
                        begin
                            mode = MODE_IDLE;
                            lex_idle(c, pos);
                        end
                    end
                    MODE_STRING:
                    begin
                        if (c == CH_QUOTE)
                        begin
                            push_token(KIND_STRING, ERR_NONE, tok_start, tok_len);
                            mode = MODE_IDLE;
                        end
                        else if (c == CH_NEWLINE)
                            raise_error(ERR_UNTERMINATED);
                        else
                            grow();
                    end
                    MODE_COMPONENT:
                    begin
                        if (is_name_char(c))
                            grow();
                        else if (tok_len == 0)
                            raise_error(ERR_NO_COMP_NAME);
                        else
                        begin
                            push_token(KIND_COMPONENT, ERR_NONE, tok_start, tok_len);
                            mode = MODE_IDLE;
                            lex_idle(c, pos);
                        end
                    end
                    MODE_IDENT:
                    begin
                        if (is_name_char(c))
                            grow();
                        else if (c == CH_COLON)
                        begin
                            push_token(KIND_PARAM, ERR_NONE, tok_start, tok_len);
                            push_token(KIND_COLON, ERR_NONE, pos, 1);
                            mode = MODE_IDLE;
                        end
                        else
                        begin
                            push_token(KIND_IDENT, ERR_NONE, tok_start, tok_len);
                            mode = MODE_IDLE;
                            lex_idle(c, pos);
                        end
                    end
                    MODE_NUMBER:
                    begin
                        if (is_digit(c))
                        begin
                            seen_digit = 1;
                            grow();
                        end
                        else if (c == CH_POINT && !seen_point)
                        begin
                            seen_point = 1;
                            grow();
                        end
                        else if (!seen_digit)
                            raise_error(ERR_NO_DIGITS);
                        else if (is_letter(c) || c == CH_POINT)
                            raise_error(ERR_BAD_NUM_END);
                        else
                        begin
                            push_token(KIND_NUMBER, ERR_NONE, tok_start, tok_len);
                            mode = MODE_IDLE;
                            lex_idle(c, pos);
                        end
                    end
                    default:
                    begin
                        mode = MODE_IDLE;
                        lex_idle(c, pos);
                    end
                endcase
                if (pos != '1)
                    pos++;

                // The last byte closes whatever token is still open, then done follows.
                if (eod && !halted)
                begin
                    case (mode)
                        MODE_SLASH:
                            raise_error(ERR_UNKNOWN_CHAR);
                        MODE_STRING:
                            raise_error(ERR_UNTERMINATED);
                        MODE_COMPONENT:
                        begin
                            if (tok_len == 0)
                                raise_error(ERR_NO_COMP_NAME);
                            else
                                push_token(KIND_COMPONENT, ERR_NONE, tok_start, tok_len);
                        end
                        MODE_IDENT:
                            push_token(KIND_IDENT, ERR_NONE, tok_start, tok_len);
                        MODE_NUMBER:
                        begin
                            if (!seen_digit)
                                raise_error(ERR_NO_DIGITS);
                            else
                                push_token(KIND_NUMBER, ERR_NONE, tok_start, tok_len);
                        end
                        default:
                        begin
                        end
                    endcase
                    if (!halted)
                        push_token(KIND_DONE, ERR_NONE, 0, 0);
                end
            end
            if (eod)
                clear_doc();
            foreach (burst[i])
            begin
                burst[i].last = (i == burst.size() - 1);
                pending_tokens.insert(pending_tokens.size(), burst[i]);
            end
            return live;
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v)
            begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        // Compares one accepted result beat with the oldest predicted token.
        function void check_token(logic [3:0] kind, logic [2:0] code, logic [31:0] line,
                                  logic [31:0] offset, logic [15:0] text_len, logic last);
            lexed_token_t t;
            if (pending_tokens.size() == 0)
            begin
                $error("result beat with no token expected: kind %0d", kind);
                errors++;
            end
            else
            begin
                t = pending_tokens.pop_front();
                compare_field("result_kind", t.kind, kind);
                compare_field("error_code", t.code, code);
                compare_field("line_number", t.line, line);
                compare_field("start_offset", t.offset, offset);
                compare_field("text_length", t.text_len, text_len);
                compare_field("last_of_run", t.last, last);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        text_valid;
    logic        text_ready;
    logic [7:0]  text_byte;
    logic        end_of_document;
    logic        result_valid;
    logic        result_ready;
    logic [3:0]  result_kind;
    logic [2:0]  error_code;
    logic [31:0] line_number;
    logic [31:0] start_offset;
    logic [15:0] text_length;
    logic        last_of_run;

    token_scoreboard sb;
    logic [7:0]      doc_text[$];
    int              send_idle_pct;
    int              recv_idle_pct;
    int              lexed_bytes;
    int              cycle_count;
    int              stall_left;
    bit              stall_request;

    scene_text_lexer u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .text_valid      (text_valid),
        .text_ready      (text_ready),
        .text_byte       (text_byte),
        .end_of_document (end_of_document),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .result_kind     (result_kind),
        .error_code      (error_code),
        .line_number     (line_number),
        .start_offset    (start_offset),
        .text_length     (text_length),
        .last_of_run     (last_of_run)
    );

    always #4 clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("scene_text_lexer test failed");
            $finish;
        end
    end

    // Result side: check each accepted beat, then choose ready for the next edge.
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            if (result_valid && result_ready)
                sb.check_token(result_kind, error_code, line_number, start_offset,
                               text_length, last_of_run);
            if (stall_request)
            begin
                stall_left    = STALL_CYCLES;
                stall_request = 1'b0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [7:0] pick_letter();
        return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'($urandom_range(25));
    endfunction

    function automatic logic [7:0] pick_digit();
        return 8'h30 + 8'($urandom_range(9));
    endfunction

    function automatic logic [7:0] pick_name_char();
        return ($urandom_range(5) == 0) ? CH_UNDER : pick_letter();
    endfunction

    // Adds one byte at the end of the document being built.
    function automatic void append_byte(input logic [7:0] c);
        doc_text.insert(doc_text.size(), c);
    endfunction

    function automatic void load_text(input string s);
        for (int i = 0; i < s.len(); i++)
            append_byte(s[i]);
    endfunction

    // Offers one byte and waits for its beat.
    task automatic offer_byte(input logic [7:0] c, input logic eod);
        while ($urandom_range(99) < send_idle_pct)
        begin
            text_valid <= 1'b0;
            @(posedge clk);
        end
        text_valid      <= 1'b1;
        text_byte       <= c;
        end_of_document <= eod;
        @(posedge clk);
        while (!text_ready)
            @(posedge clk);
        if (sb.note_text_beat(c, eod))
            lexed_bytes++;
    endtask

    task automatic send_document();
        foreach (doc_text[i])
            offer_byte(doc_text[i], i == doc_text.size() - 1);
        doc_text.delete();
    endtask

    // Stops offering bytes and waits until every predicted token has come out.
    task automatic wait_drained();
        text_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_tokens.size() != 0)
            @(posedge clk);
    endtask

    // Random documents built from token fragments; a quarter of them may carry broken ones.
    task automatic send_random_documents(input int target);
        int         n_frag;
        int         choice;
        bit         noisy;
        logic [7:0] c;
        while (lexed_bytes < target)
        begin
            noisy  = ($urandom_range(3) == 0);
            n_frag = $urandom_range(10, 1);
            repeat (n_frag)
            begin
                choice = $urandom_range(noisy ? 99 : 85);
                if (choice < 12)
                begin
                    append_byte(CH_QUOTE);
                    repeat ($urandom_range(6))
                    begin
                        c = 8'($urandom_range(255));
                        append_byte((c == CH_QUOTE || c == CH_NEWLINE) ? 8'h78 : c);
                    end
                    append_byte(CH_QUOTE);
                end
                else if (choice < 24)
                begin
                    append_byte(CH_AT);
                    repeat ($urandom_range(5, 1))
                        append_byte(pick_name_char());
                end
                else if (choice < 48)
                begin
                    append_byte(pick_letter());
                    repeat ($urandom_range(5))
                        append_byte(pick_name_char());
                    if (choice >= 38)
                        append_byte(CH_COLON);
                end
                else if (choice < 62)
                begin
                    if ($urandom_range(1))
                        append_byte(CH_MINUS);
                    repeat ($urandom_range(4, 1))
                        append_byte(pick_digit());
                    if ($urandom_range(1))
                    begin
                        append_byte(CH_POINT);
                        repeat ($urandom_range(3))
                            append_byte(pick_digit());
                    end
                end
                else if (choice < 72)
                begin
                    case ($urandom_range(4))
                        0: append_byte(CH_LBRACE);
                        1: append_byte(CH_RBRACE);
                        2: append_byte(CH_LSQUARE);
                        3: append_byte(CH_RSQUARE);
                        default: append_byte(CH_COLON);
                    endcase
                end
                else if (choice < 80)
                begin
                    case ($urandom_range(6))
                        0: append_byte(CH_SPACE);
                        1: append_byte(CH_TAB);
                        2: append_byte(CH_VTAB);
                        3: append_byte(CH_FEED);
                        4: append_byte(CH_CR);
                        5: append_byte(CH_COMMA);
                        default: append_byte(CH_NEWLINE);
                    endcase
                end
                else if (choice < 86)
                begin
                    append_byte(CH_SLASH);
                    append_byte(CH_SLASH);
                    repeat ($urandom_range(5))
                    begin
                        c = 8'($urandom_range(255));
                        append_byte((c == CH_NEWLINE) ? CH_SPACE : c);
                    end
                    append_byte(CH_NEWLINE);
                end
                else
                begin
                    // Broken sequences and stray bytes.
                    case ($urandom_range(8))
                        0:
                        begin
                            append_byte(CH_QUOTE);
                            append_byte(pick_letter());
                            append_byte(CH_NEWLINE);
                        end
                        1:
                        begin
                            append_byte(CH_AT);
                            append_byte($urandom_range(1) ? CH_SPACE : pick_digit());
                        end
                        2:
                        begin
                            append_byte(CH_MINUS);
                            append_byte($urandom_range(1) ? CH_SPACE : pick_letter());
                        end
                        3:
                        begin
                            append_byte(pick_digit());
                            if ($urandom_range(1))
                                append_byte(CH_POINT);
                            append_byte($urandom_range(1) ? CH_POINT : pick_letter());
                        end
                        4:
                        begin
                            append_byte(CH_SLASH);
                            append_byte(8'($urandom_range(255)));
                        end
                        5: append_byte(8'($urandom_range(255)));
                        6: append_byte(8'($urandom_range(255, 128)));
                        7: append_byte($urandom_range(1) ? CH_UNDER : CH_POINT);
                        default: append_byte($urandom_range(1) ?
                            8'($urandom_range(8)) : 8'($urandom_range(31, 14)));
                    endcase
                end
                // Usually a separator, so tokens do not run into each other.
                if ($urandom_range(9) < 6)
                    append_byte($urandom_range(3) == 0 ? CH_NEWLINE : CH_SPACE);
            end
            send_document();
        end
    endtask

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        text_valid      = 1'b0;
        text_byte       = 8'h00;
        end_of_document = 1'b0;
        result_ready    = 1'b0;
        cycle_count     = 0;
        stall_left      = 0;
        stall_request   = 1'b0;
        lexed_bytes     = 0;
        sb              = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 8;
        recv_idle_pct = 71;

        // Every token kind but error, a comment, and an identifier still open at the last byte.
        load_text("k:\"s\"@C[-1.5],{}\n//\nid");
        send_document();
        // A high byte is unknown; the byte after the error gives nothing, not even done.
        doc_text = '{8'hFF, 8'h00};
        send_document();
        // A lone slash as the whole document.
        append_byte(CH_SLASH);
        send_document();

        send_random_documents(100);
        wait_drained();

        send_idle_pct = 71;
        recv_idle_pct = 8;
        send_random_documents(185);
        wait_drained();

        // No idling; the receiver first holds off long enough for the queue to fill.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_request = 1'b1;
        load_text("{[]}{[]}:{}[]{}");
        send_document();
        send_random_documents(270);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending_tokens.size() == 0)
            $display("scene_text_lexer test passed");
        else
            $display("scene_text_lexer test failed");
        $finish;
    end
endmodule
